### hw/rtl/efs_pkg.sv
// Package for the elevator floor scheduler: request and response payload types,
// command and motion codes, floor count and the controller-to-datapath command struct.
// No dependencies.
package efs_pkg;

  localparam int Floors = 16;
  localparam int FloorW = 4;
  localparam logic [FloorW-1:0] LastFloor = FloorW'(Floors - 1);
  localparam logic [7:0] CapacityReset = 8'd8;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_ADD  = 2'd1;
  localparam logic [1:0] CMD_STOP = 2'd2;

  localparam logic [1:0] MOT_STOP = 2'd0;
  localparam logic [1:0] MOT_UP   = 2'd1;
  localparam logic [1:0] MOT_DOWN = 2'd2;

  typedef struct packed {
    logic [1:0]        command;
    logic [FloorW-1:0] floor;
    logic [7:0]        person_count;
  } efs_req_t;

  typedef struct packed {
    logic [FloorW-1:0] current_floor;
    logic [FloorW-1:0] target_floor;
    logic [1:0]        direction;
    logic [7:0]        onboard;
    logic              full_res;
    logic [FloorW-1:0] stop_floor;
    logic              stop_valid;
  } efs_rsp_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic capture;  // latch the request and read its pending entry
    logic exec;     // apply the request and load the response register
  } efs_cmd_t;

endpackage

### hw/rtl/efs_ctrl.sv
// Controller for the elevator floor scheduler: two-state sequencer plus output valid.
// Depends on efs_pkg for the command struct.
module efs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output efs_pkg::efs_cmd_t cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept, exec;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && (state_q == StIdle);
  // Hold in execute until the response register is free or being taken.
  assign exec       = (state_q == StExec) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) state_d = StExec;
      end
      StExec: begin
        if (exec) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (exec) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cmd_o.capture = accept;
  assign cmd_o.exec    = exec;

endmodule

### hw/rtl/efs_dp.sv
// Datapath for the elevator floor scheduler: car state, pending-count memory with
// nonzero flags, lowest-pending search and the response register. Depends on efs_pkg.
module efs_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  efs_pkg::efs_cmd_t cmd_i,
  input  efs_pkg::efs_req_t req_i,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  output efs_pkg::efs_rsp_t rsp_o
);

  localparam int FW = efs_pkg::FloorW;

  // Pending counts; nz_q marks entries that hold a nonzero count, so reset
  // needs no sweep of the memory.
  logic [7:0] pend_mem [efs_pkg::Floors];
  logic [7:0] rdata_q;
  logic [efs_pkg::Floors-1:0] nz_q, nz_d;

  efs_pkg::efs_req_t req_q;
  efs_pkg::efs_rsp_t rsp_q, rsp_d;

  logic [FW-1:0] car_q, car_d, goal_q, goal_d, via_q, via_d;
  logic [1:0]    mot_q, mot_d;
  logic [7:0]    riders_q, riders_d, cap_q;
  logic          via_valid_q, via_valid_d;

  logic [FW-1:0] raddr, rsel, low_floor;
  logic          in_range;
  logic [7:0]    entry, wdata;
  logic [8:0]    pend_sum, rider_sum;
  logic          mem_we;

  function automatic logic [1:0] toward(logic [FW-1:0] from, logic [FW-1:0] to);
    toward = (from > to) ? efs_pkg::MOT_DOWN : efs_pkg::MOT_UP;
  endfunction

  // Tick reads the car's own floor; add reads the target floor.
  assign raddr = (req_i.command == efs_pkg::CMD_TICK) ? car_q : req_i.floor;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rdata_q <= pend_mem[raddr];
      req_q   <= req_i;
    end
    if (cmd_i.exec && mem_we) pend_mem[req_q.floor] <= wdata;
    if (cmd_i.exec) rsp_q <= rsp_d;
  end

  always_comb begin
    low_floor = '0;
    for (int i = efs_pkg::Floors - 1; i >= 0; i--) begin
      if (nz_q[i]) low_floor = FW'(i);
    end
  end

  // Same address as the captured read; the car does not move in between.
  assign rsel      = (req_q.command == efs_pkg::CMD_TICK) ? car_q : req_q.floor;
  assign in_range  = (32'(req_q.floor) < efs_pkg::Floors);
  assign entry     = nz_q[rsel] ? rdata_q : 8'd0;
  assign pend_sum  = {1'b0, entry} + {1'b0, req_q.person_count};
  assign rider_sum = {1'b0, riders_q} + {1'b0, req_q.person_count};
  assign wdata     = pend_sum[8] ? 8'hFF : pend_sum[7:0];

  always_comb begin
    car_d       = car_q;
    goal_d      = goal_q;
    mot_d       = mot_q;
    riders_d    = riders_q;
    via_d       = via_q;
    via_valid_d = via_valid_q;
    nz_d        = nz_q;
    mem_we      = 1'b0;
    case (req_q.command)
      efs_pkg::CMD_TICK: begin
        if (mot_q == efs_pkg::MOT_STOP) begin
          if (entry != 8'd0) begin
            // Serve the waiting passengers at this floor.
            riders_d    = (riders_q > entry) ? riders_q - entry : 8'd0;
            nz_d[car_q] = 1'b0;
            mot_d       = toward(car_q, goal_q);
          end else if (goal_q != car_q) begin
            mot_d = toward(car_q, goal_q);
          end else begin
            mot_d = efs_pkg::MOT_STOP;
            if (|nz_q) begin
              goal_d = low_floor;
              if (low_floor > car_q) begin
                mot_d = efs_pkg::MOT_UP;
                car_d = car_q + 1'b1;
              end else if (low_floor < car_q) begin
                mot_d = efs_pkg::MOT_DOWN;
                car_d = car_q - 1'b1;
              end
            end
            if (mot_d == efs_pkg::MOT_STOP && via_valid_q) begin
              if (car_q < via_q) mot_d = efs_pkg::MOT_UP;
              else if (car_q > via_q) mot_d = efs_pkg::MOT_DOWN;
            end
          end
        end else if (mot_q == efs_pkg::MOT_UP) begin
          if (car_q != efs_pkg::LastFloor) car_d = car_q + 1'b1;
          else mot_d = efs_pkg::MOT_STOP;
        end else if (mot_q == efs_pkg::MOT_DOWN) begin
          if (car_q != '0) car_d = car_q - 1'b1;
          else mot_d = efs_pkg::MOT_STOP;
        end
        if (car_d == goal_d || (via_valid_q && car_d == via_q)) mot_d = efs_pkg::MOT_STOP;
      end
      efs_pkg::CMD_ADD: begin
        if (in_range) begin
          mem_we            = 1'b1;
          nz_d[req_q.floor] = |wdata;
          riders_d          = rider_sum[8] ? 8'hFF : rider_sum[7:0];
          if (via_valid_q && via_q == goal_q) via_valid_d = 1'b0;
        end
      end
      efs_pkg::CMD_STOP: begin
        if (in_range) begin
          via_d       = req_q.floor;
          via_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    rsp_d.current_floor = car_d;
    rsp_d.target_floor  = goal_d;
    rsp_d.direction     = mot_d;
    rsp_d.onboard       = riders_d;
    rsp_d.full_res      = (riders_d >= cap_q);
    rsp_d.stop_floor    = via_d;
    rsp_d.stop_valid    = via_valid_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      car_q       <= '0;
      goal_q      <= '0;
      mot_q       <= efs_pkg::MOT_STOP;
      riders_q    <= '0;
      via_q       <= '0;
      via_valid_q <= 1'b0;
      nz_q        <= '0;
      cap_q       <= efs_pkg::CapacityReset;
    end else begin
      if (cmd_i.exec) begin
        car_q       <= car_d;
        goal_q      <= goal_d;
        mot_q       <= mot_d;
        riders_q    <= riders_d;
        via_q       <= via_d;
        via_valid_q <= via_valid_d;
        nz_q        <= nz_d;
      end
      if (cfg_we_i) cap_q <= cfg_wdata_i;
    end
  end

  assign rsp_o = rsp_q;

endmodule

### hw/rtl/elevator_floor_scheduler.sv
// Elevator floor scheduler top level.
// The pending memory is read at the accept edge; the update and the response load follow
// in the execute state, which holds while an earlier response waits on out_stall_i.
// A new request is not taken until the previous one is applied (memory read, then update),
// but it is taken while an earlier response still waits.
// Reset (rst_ni low, asynchronous): car at floor 0, stopped, no riders, no stop,
// no pending floors (flag bits cleared at once), capacity 8.
module elevator_floor_scheduler (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  efs_pkg::efs_req_t in_req_i,
  // response channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output efs_pkg::efs_rsp_t out_rsp_o,
  // capacity register write
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i
);

  efs_pkg::efs_cmd_t cmd;

  // Sequencer: accept in idle, apply in execute once the response slot is free.
  efs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Car state, pending counts, floor search and response register.
  efs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (in_req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rsp_o       (out_rsp_o)
  );

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for elevator_floor_scheduler: streams car requests, predicts
// every status response with a behavioral car model and checks them in order.
// Depends on efs_pkg and the elevator_floor_scheduler RTL.
module tb_top;
  import efs_pkg::*;

  // Command code 3 has no name in the package; the car must ignore it.
  localparam logic [1:0] CMD_NONE   = 2'd3;
  localparam int         IdlePct    = 19;
  localparam int         QuietLimit = 2000;
  localparam int         MaxReports = 30;
  localparam int         PhaseItems = 100;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  efs_req_t   in_req_i    = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  efs_rsp_t   out_rsp_o;
  logic       cfg_we_i    = 1'b0;
  logic [7:0] cfg_wdata_i = '0;

  elevator_floor_scheduler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Car model: its own copy of the controller state and the capacity register.
  // ---------------------------------------------------------------------------
  logic [7:0]        waiting_m [Floors];  // pending passengers per floor
  logic [FloorW-1:0] car_m;
  logic [FloorW-1:0] goal_m;
  logic [FloorW-1:0] via_m;
  logic              via_ok_m;
  logic [1:0]        dir_m;
  logic [7:0]        riders_m;
  logic [7:0]        cap_m;

  efs_req_t request_q[$];     // requests not yet handed to the driver
  efs_rsp_t car_status_q[$];  // predicted responses, oldest first

  int idle_pct = IdlePct;
  int n_mismatch = 0;
  int n_requests = 0;
  int n_responses = 0;
  int cmd_seen [4] = '{0, 0, 0, 0};
  int quiet_cycles = 0;

  function automatic logic [7:0] sat_add(logic [7:0] a, logic [7:0] b);
    logic [8:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[8] ? 8'hFF : sum[7:0];
  endfunction

  function automatic logic [1:0] heading(logic [FloorW-1:0] from, logic [FloorW-1:0] to);
    return (from > to) ? MOT_DOWN : MOT_UP;
  endfunction

  // Step one floor in the current direction; stop at either end of the shaft.
  function automatic void move_car();
    if (dir_m == MOT_UP) begin
      if (car_m != LastFloor) car_m = car_m + 1'b1;
      else dir_m = MOT_STOP;
    end else if (dir_m == MOT_DOWN) begin
      if (car_m != '0) car_m = car_m - 1'b1;
      else dir_m = MOT_STOP;
    end
  endfunction

  function automatic void tick_car();
    logic found;
    found = 1'b0;
    if (dir_m == MOT_STOP) begin
      if (waiting_m[car_m] != '0) begin
        // Serve this floor: drop riders (floor at zero), clear it, face the goal.
        riders_m = (riders_m > waiting_m[car_m]) ? riders_m - waiting_m[car_m] : 8'd0;
        waiting_m[car_m] = '0;
        dir_m = heading(car_m, goal_m);
      end else if (goal_m != car_m) begin
        dir_m = heading(car_m, goal_m);
      end else begin
        // Lowest pending floor becomes the goal; the first step is taken at once.
        for (int f = 0; f < Floors; f++) begin
          if (!found && waiting_m[f] != '0) begin
            found = 1'b1;
            goal_m = FloorW'(f);
            if (goal_m != car_m) begin
              dir_m = heading(car_m, goal_m);
              move_car();
            end
          end
        end
        if (dir_m == MOT_STOP && via_ok_m && via_m != car_m) dir_m = heading(car_m, via_m);
      end
    end else begin
      move_car();
    end
    if (car_m == goal_m || (via_ok_m && car_m == via_m)) dir_m = MOT_STOP;
  endfunction

  function automatic efs_rsp_t apply_request(efs_req_t r);
    efs_rsp_t s;
    case (r.command)
      CMD_TICK: tick_car();
      CMD_ADD: begin
        if (int'(r.floor) < Floors) begin
          waiting_m[r.floor] = sat_add(waiting_m[r.floor], r.person_count);
          riders_m = sat_add(riders_m, r.person_count);
          // A stop that coincides with the goal is dropped by any add.
          if (via_ok_m && via_m == goal_m) via_ok_m = 1'b0;
        end
      end
      CMD_STOP: begin
        if (int'(r.floor) < Floors) begin
          via_m = r.floor;
          via_ok_m = 1'b1;
        end
      end
      default: ;
    endcase
    s.current_floor = car_m;
    s.target_floor  = goal_m;
    s.direction     = dir_m;
    s.onboard       = riders_m;
    s.full_res      = (riders_m >= cap_m);
    s.stop_floor    = via_m;
    s.stop_valid    = via_ok_m;
    return s;
  endfunction

  function automatic void push_req(logic [1:0] cmd, int fl, int cnt);
    efs_req_t r;
    r.command      = cmd;
    r.floor        = FloorW'(fl);
    r.person_count = 8'(cnt);
    request_q.push_back(r);
  endfunction

  // Mostly ticks and small adds so the car actually travels and serves floors;
  // one add in eight uses the full count range to hit saturation and full.
  function automatic efs_req_t random_request();
    efs_req_t r;
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) r.command = CMD_TICK;
    else if (pick < 80) r.command = CMD_ADD;
    else if (pick < 94) r.command = CMD_STOP;
    else r.command = CMD_NONE;
    r.floor = FloorW'($urandom_range(Floors - 1));
    r.person_count = ($urandom_range(7) == 0) ? 8'($urandom_range(255))
                                              : 8'($urandom_range(12));
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (n_mismatch < MaxReports) $display("mismatch: %s", msg);
    n_mismatch++;
  endtask

  task automatic compare_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("response %0d %s got %0d want %0d",
                                n_responses, name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present queued requests, hold while stalled, idle at random.
  // The prediction is made at the edge where the request is accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        car_status_q.push_back(apply_request(in_req_i));
        cmd_seen[in_req_i.command]++;
        n_requests++;
      end
      // Hold the payload while stalled; otherwise advance or idle.
      if (!in_valid_i || !in_stall_o) begin
        if (request_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_req_i   <= request_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each accepted response against the oldest prediction and
  // drive random stalls on the response channel.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    efs_rsp_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (car_status_q.size() == 0) begin
          report_mismatch($sformatf("response %0d arrived with no request waiting",
                                    n_responses));
        end else begin
          want = car_status_q.pop_front();
          compare_field("current_floor", 8'(out_rsp_o.current_floor), 8'(want.current_floor));
          compare_field("target_floor", 8'(out_rsp_o.target_floor), 8'(want.target_floor));
          compare_field("direction", 8'(out_rsp_o.direction), 8'(want.direction));
          compare_field("onboard", out_rsp_o.onboard, want.onboard);
          compare_field("full_res", 8'(out_rsp_o.full_res), 8'(want.full_res));
          compare_field("stop_floor", 8'(out_rsp_o.stop_floor), 8'(want.stop_floor));
          compare_field("stop_valid", 8'(out_rsp_o.stop_valid), 8'(want.stop_valid));
        end
        n_responses++;
      end
      out_stall_i <= ($urandom_range(99) < idle_pct);
    end
  end

  // Watchdog: end the run when neither channel moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("watchdog: nothing accepted for %0d cycles", quiet_cycles);
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Block until every queued request went out and every response came back.
  task automatic drain();
    while (request_q.size() != 0 || in_valid_i || car_status_q.size() != 0)
      @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed requests at the reset capacity, then random
  // phases, each under a new capacity written while the car is idle.
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] cap_plan [4];
    foreach (waiting_m[f]) waiting_m[f] = '0;
    car_m    = '0;
    goal_m   = '0;
    via_m    = '0;
    via_ok_m = 1'b0;
    dir_m    = MOT_STOP;
    riders_m = '0;
    cap_m    = CapacityReset;
    cap_plan = '{8'd0, 8'd255, 8'($urandom_range(254, 1)), 8'd9};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Idle tick with nothing pending, then an unused command with maxed fields.
    push_req(CMD_TICK, 0, 0);
    push_req(CMD_NONE, 15, 255);
    // Stop above the car: the car sits at its goal, so it stays stopped on both ticks.
    push_req(CMD_STOP, 12, 0);
    push_req(CMD_TICK, 0, 0);
    push_req(CMD_TICK, 0, 0);
    // Move the stop to the car's floor: the car stays stopped at floor 0 through every tick.
    push_req(CMD_STOP, 0, 0);
    repeat (15) push_req(CMD_TICK, 0, 0);
    // Saturating adds at the top floor; the stop equals the goal and is dropped.
    push_req(CMD_ADD, 15, 255);
    push_req(CMD_ADD, 15, 255);
    push_req(CMD_ADD, 0, 0);
    // The top floor becomes the goal and the car steps up toward it on each tick.
    push_req(CMD_TICK, 0, 0);
    push_req(CMD_TICK, 0, 0);
    drain();

    for (int p = 0; p < 4; p++) begin
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= cap_plan[p];
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      cap_m = cap_plan[p];
      // The second phase runs with no idling on either side.
      idle_pct = (p == 1) ? 0 : IdlePct;
      repeat (PhaseItems) request_q.push_back(random_request());
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (car_status_q.size() != 0)
      report_mismatch($sformatf("%0d responses never arrived", car_status_q.size()));
    $display("covered %0d requests (%0d ticks, %0d adds, %0d stop sets, %0d unused), %0d responses",
             n_requests, cmd_seen[CMD_TICK], cmd_seen[CMD_ADD], cmd_seen[CMD_STOP],
             cmd_seen[CMD_NONE], n_responses);
    $display("capacity: reset value, then %0d, %0d, %0d, %0d; %0d mismatches",
             cap_plan[0], cap_plan[1], cap_plan[2], cap_plan[3], n_mismatch);
    if (n_mismatch == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
